@@ sv/jpt_pkg.sv @@
// Shared types for the JSON path tokenizer.
// Holds the token kind codes and the per-item result record.
// Used by jpt_scan and json_path_tokenizer_unit; depends on nothing.
package jpt_pkg;

  typedef enum logic [1:0] {
    KIND_QUOTED    = 2'd0,
    KIND_WILDCARD  = 2'd1,
    KIND_KEY       = 2'd2,
    KIND_RECURSIVE = 2'd3
  } kind_e;

  typedef struct packed {
    logic       has_char;
    logic [7:0] key_char;
    logic       token_end;
    kind_e      token_kind;
    logic       path_error;
    logic       path_done;
  } res_t;

endpackage

@@ sv/json_path_tokenizer_unit.sv @@
// Top level of the JSON path tokenizer: input register, scanner, result register.
// Depends on jpt_pkg and jpt_scan.
//
// The unit takes one path byte per item and gives exactly one result item per
// input item. It accepts a new byte in every cycle as long as the output side
// keeps taking results. A byte accepted into the input register has its result
// captured in the result register, which drives the outputs, once it advances.
// The scanner state is updated once per byte as the byte moves from the input
// register into the result register. Errors are sticky until the byte flagged
// as last, after which the scanner is ready for a new path.
module json_path_tokenizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] path_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       has_char_o,
  output logic [7:0] key_char_o,
  output logic       token_end_o,
  output logic [1:0] token_kind_o,
  output logic       path_error_o,
  output logic       path_done_o
);

  logic          s1_valid_q;
  logic [7:0]    s1_byte_q;
  logic          s1_last_q;
  logic          s2_valid_q;
  jpt_pkg::res_t s2_res_q;
  jpt_pkg::res_t scan_res;
  logic          s1_adv;
  logic          in_take;

  assign s1_adv  = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_take = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !s1_adv;

  jpt_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .res_o  (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= path_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s1_adv) begin
      s2_res_q <= scan_res;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign has_char_o   = s2_res_q.has_char;
  assign key_char_o   = s2_res_q.key_char;
  assign token_end_o  = s2_res_q.token_end;
  assign token_kind_o = s2_res_q.token_kind;
  assign path_error_o = s2_res_q.path_error;
  assign path_done_o  = s2_res_q.path_done;

  // An erroneous result carries neither a character nor a token end.
  a_err_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && path_error_o) |-> (!has_char_o && !token_end_o))
    else $error("error result carries key data");

  // A kind is only reported together with a token end.
  a_kind_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !token_end_o) |-> (token_kind_o == jpt_pkg::KIND_QUOTED))
    else $error("token kind without token end");

  // A byte held in the input register stays there until it advances.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q)))
    else $error("input register lost a stalled item");

endmodule

@@ sv/jpt_scan.sv @@
// Scanner state and per-byte transition logic of the JSON path tokenizer.
// Produces the result record of one byte combinationally and updates the
// scan state when the item advances. Depends on jpt_pkg.
module jpt_scan (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         adv_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output jpt_pkg::res_t res_o
);

  typedef enum logic [3:0] {
    M_FIRST    = 4'd0,
    M_TOKSTART = 4'd1,
    M_AFTERDOT = 4'd2,
    M_AFTERREC = 4'd3,
    M_DOTKEY   = 4'd4,
    M_BROPEN   = 4'd5,
    M_QUOTED   = 4'd6,
    M_QESC     = 4'd7,
    M_QCLOSE   = 4'd8,
    M_UKEY     = 4'd9,
    M_UCLOSE   = 4'd10
  } mode_e;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic logic is_ws(input logic [7:0] b);
    return (b inside {CH_SPACE, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_unquoted(input logic [7:0] b);
    return (b inside {CH_UNDER, CH_STAR, CH_DASH, [8'h30:8'h39], [8'h41:8'h5A],
                      [8'h61:8'h7A]});
  endfunction

  mode_e      mode_q, mode_d;
  logic [7:0] held_char_q, held_char_d;
  logic       held_valid_q, held_valid_d;
  logic       len_one_q, len_one_d;
  logic       quote_single_q, quote_single_d;
  logic       quoted_nonempty_q, quoted_nonempty_d;
  logic       err_q, err_d;

  logic       err_n;
  logic [7:0] quote_ch;
  logic       lone_star;

  always_comb begin
    mode_d            = mode_q;
    held_char_d       = held_char_q;
    held_valid_d      = held_valid_q;
    len_one_d         = len_one_q;
    quote_single_d    = quote_single_q;
    quoted_nonempty_d = quoted_nonempty_q;
    err_n             = err_q;
    res_o             = '0;
    res_o.token_kind  = jpt_pkg::KIND_QUOTED;
    quote_ch          = quote_single_q ? CH_SQUOTE : CH_DQUOTE;
    lone_star         = len_one_q && (held_char_q == CH_STAR);

    if (!err_q) begin
      case (mode_q)
        M_FIRST, M_AFTERDOT, M_AFTERREC: begin
          if ((mode_q == M_FIRST) && ((byte_i == CH_DOLLAR) || (byte_i == CH_AT))) begin
            mode_d = M_TOKSTART;
          end else if (byte_i == CH_DOT) begin
            if ((mode_q == M_AFTERREC) || last_i) begin
              err_n = 1'b1;
            end else begin
              res_o.token_end  = 1'b1;
              res_o.token_kind = jpt_pkg::KIND_RECURSIVE;
              mode_d           = M_AFTERREC;
            end
          end else if (byte_i == CH_LBRACK) begin
            mode_d = M_BROPEN;
          end else if (byte_i == CH_STAR) begin
            res_o.token_end  = 1'b1;
            res_o.token_kind = jpt_pkg::KIND_WILDCARD;
            mode_d           = M_TOKSTART;
          end else if (is_ws(byte_i) || (byte_i == CH_LPAREN)) begin
            err_n = 1'b1;
          end else begin
            res_o.has_char = 1'b1;
            res_o.key_char = byte_i;
            if (last_i) begin
              res_o.token_end  = 1'b1;
              res_o.token_kind = jpt_pkg::KIND_KEY;
            end
            mode_d = M_DOTKEY;
          end
        end
        M_TOKSTART: begin
          if (byte_i == CH_DOT) begin
            mode_d = M_AFTERDOT;
          end else if (byte_i == CH_LBRACK) begin
            mode_d = M_BROPEN;
          end else begin
            err_n = 1'b1;
          end
        end
        M_DOTKEY: begin
          if ((byte_i == CH_DOT) || (byte_i == CH_LBRACK)) begin
            res_o.token_end  = 1'b1;
            res_o.token_kind = jpt_pkg::KIND_KEY;
            mode_d           = (byte_i == CH_DOT) ? M_AFTERDOT : M_BROPEN;
          end else if ((byte_i == CH_LPAREN) || is_ws(byte_i)) begin
            err_n = 1'b1;
          end else begin
            res_o.has_char = 1'b1;
            res_o.key_char = byte_i;
            if (last_i) begin
              res_o.token_end  = 1'b1;
              res_o.token_kind = jpt_pkg::KIND_KEY;
            end
          end
        end
        M_BROPEN: begin
          if (is_ws(byte_i)) begin
            mode_d = M_BROPEN;
          end else if ((byte_i == CH_DQUOTE) || (byte_i == CH_SQUOTE)) begin
            quote_single_d    = (byte_i == CH_SQUOTE);
            quoted_nonempty_d = 1'b0;
            mode_d            = M_QUOTED;
          end else if (is_unquoted(byte_i)) begin
            held_char_d  = byte_i;
            held_valid_d = 1'b1;
            len_one_d    = 1'b1;
            mode_d       = M_UKEY;
          end else begin
            err_n = 1'b1;
          end
        end
        M_QUOTED: begin
          if (byte_i == CH_BSLASH) begin
            mode_d = M_QESC;
          end else if (byte_i == quote_ch) begin
            if (quoted_nonempty_q) begin
              mode_d = M_QCLOSE;
            end else begin
              err_n = 1'b1;
            end
          end else begin
            res_o.has_char    = 1'b1;
            res_o.key_char    = byte_i;
            quoted_nonempty_d = 1'b1;
          end
        end
        M_QESC: begin
          if ((byte_i == quote_ch) || (byte_i == CH_BSLASH)) begin
            res_o.has_char    = 1'b1;
            res_o.key_char    = byte_i;
            quoted_nonempty_d = 1'b1;
            mode_d            = M_QUOTED;
          end else begin
            err_n = 1'b1;
          end
        end
        M_QCLOSE: begin
          if (is_ws(byte_i)) begin
            mode_d = M_QCLOSE;
          end else if (byte_i == CH_RBRACK) begin
            res_o.token_end  = 1'b1;
            res_o.token_kind = jpt_pkg::KIND_QUOTED;
            mode_d           = M_TOKSTART;
          end else begin
            err_n = 1'b1;
          end
        end
        M_UKEY: begin
          if (is_unquoted(byte_i)) begin
            res_o.has_char = 1'b1;
            res_o.key_char = held_char_q;
            held_char_d    = byte_i;
            held_valid_d   = 1'b1;
            len_one_d      = 1'b0;
          end else if (is_ws(byte_i) || (byte_i == CH_RBRACK)) begin
            // The held character goes out now unless the key is a lone star.
            if (held_valid_q && !lone_star) begin
              res_o.has_char = 1'b1;
              res_o.key_char = held_char_q;
            end
            held_valid_d = 1'b0;
            if (byte_i == CH_RBRACK) begin
              res_o.token_end  = 1'b1;
              res_o.token_kind = lone_star ? jpt_pkg::KIND_WILDCARD : jpt_pkg::KIND_KEY;
              mode_d           = M_TOKSTART;
            end else begin
              mode_d = M_UCLOSE;
            end
          end else begin
            err_n = 1'b1;
          end
        end
        M_UCLOSE: begin
          if (is_ws(byte_i)) begin
            mode_d = M_UCLOSE;
          end else if (byte_i == CH_RBRACK) begin
            res_o.token_end  = 1'b1;
            res_o.token_kind = lone_star ? jpt_pkg::KIND_WILDCARD : jpt_pkg::KIND_KEY;
            mode_d           = M_TOKSTART;
          end else begin
            err_n = 1'b1;
          end
        end
        default: begin
          err_n = 1'b1;
        end
      endcase
      // A path may only end after the root marker or a complete token, or inside a dot key.
      if (last_i && !err_n && (mode_d != M_TOKSTART) && (mode_d != M_DOTKEY)) begin
        err_n = 1'b1;
      end
    end

    if (err_n) begin
      res_o.has_char   = 1'b0;
      res_o.key_char   = '0;
      res_o.token_end  = 1'b0;
      res_o.token_kind = jpt_pkg::KIND_QUOTED;
    end
    res_o.path_error = err_n;
    res_o.path_done  = last_i;
    err_d            = err_n;

    if (last_i) begin
      mode_d            = M_FIRST;
      held_char_d       = '0;
      held_valid_d      = 1'b0;
      len_one_d         = 1'b0;
      quote_single_d    = 1'b0;
      quoted_nonempty_d = 1'b0;
      err_d             = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q            <= M_FIRST;
      held_char_q       <= '0;
      held_valid_q      <= 1'b0;
      len_one_q         <= 1'b0;
      quote_single_q    <= 1'b0;
      quoted_nonempty_q <= 1'b0;
      err_q             <= 1'b0;
    end else if (adv_i) begin
      mode_q            <= mode_d;
      held_char_q       <= held_char_d;
      held_valid_q      <= held_valid_d;
      len_one_q         <= len_one_d;
      quote_single_q    <= quote_single_d;
      quoted_nonempty_q <= quoted_nonempty_d;
      err_q             <= err_d;
    end
  end

endmodule

@@ tb/tb_json_path_tokenizer_unit.sv @@
// Self-checking testbench for json_path_tokenizer_unit: directed paths, then random paths.
// Results are checked against a cycle-free scanner model here, or typed rows where given.
// Depends on jpt_pkg and the tokenizer RTL only.
module tb_json_path_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int unsigned RAND_ITEMS  = 2000;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [3:0] {
    S_FIRST, S_TOKSTART, S_AFTERDOT, S_AFTERREC, S_DOTKEY, S_BROPEN,
    S_QUOTED, S_QESC, S_QCLOSE, S_UKEY, S_UCLOSE
  } scan_mode_e;

  typedef struct {
    logic [7:0]    pb;
    logic          lb;
    bit            typed;
    jpt_pkg::res_t res;
  } path_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] path_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       has_char_o;
  logic [7:0] key_char_o;
  logic       token_end_o;
  logic [1:0] token_kind_o;
  logic       path_error_o;
  logic       path_done_o;

  // Typed expectation travelling with the item currently offered.
  bit            row_typed = 1'b0;
  jpt_pkg::res_t row_res = '0;

  // Scanner state of the model.
  scan_mode_e mode;
  logic [7:0] held_char;
  logic       held_valid, key_one, quote_single, quoted_nonempty, err_seen;

  jpt_pkg::res_t pending_res[$];
  path_row_t     directed_rows[$];
  logic [7:0]    path_buf[$];

  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned n_items = 0, n_paths = 0, n_bad_paths = 0, n_tokens = 0, n_chars = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_style = 0;

  json_path_tokenizer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .path_byte_i  (path_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .has_char_o   (has_char_o),
    .key_char_o   (key_char_o),
    .token_end_o  (token_end_o),
    .token_kind_o (token_kind_o),
    .path_error_o (path_error_o),
    .path_done_o  (path_done_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------- scanner model

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_bare(input logic [7:0] b);
    return b == CH_USCORE || b == CH_STAR || b == CH_DASH ||
           (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic void clear_scan();
    mode = S_FIRST;
    held_char = 8'h00;
    held_valid = 1'b0;
    key_one = 1'b0;
    quote_single = 1'b0;
    quoted_nonempty = 1'b0;
    err_seen = 1'b0;
  endfunction

  // Byte after a dot or non-root first byte; rec: that dot closed a recursive token.
  function automatic void follow_dot(input logic [7:0] b, input logic last, input logic rec,
                                     inout jpt_pkg::res_t r);
    if (b == CH_DOT) begin
      if (rec || last) begin
        err_seen = 1'b1;
      end else begin
        r.token_end = 1'b1;
        r.token_kind = jpt_pkg::KIND_RECURSIVE;
        mode = S_AFTERREC;
      end
    end else if (b == CH_LBRACK) begin
      mode = S_BROPEN;
    end else if (b == CH_STAR) begin
      r.token_end = 1'b1;
      r.token_kind = jpt_pkg::KIND_WILDCARD;
      mode = S_TOKSTART;
    end else if (is_space(b) || b == CH_LPAREN) begin
      err_seen = 1'b1;
    end else begin
      r.has_char = 1'b1;
      r.key_char = b;
      if (last) begin
        r.token_end = 1'b1;
        r.token_kind = jpt_pkg::KIND_KEY;
      end
      mode = S_DOTKEY;
    end
  endfunction

  function automatic jpt_pkg::res_t scan_byte(input logic [7:0] b, input logic last);
    jpt_pkg::res_t r;
    logic [7:0]    q;
    logic          star;
    r = '0;
    if (!err_seen) begin
      q = quote_single ? CH_SQUOTE : CH_DQUOTE;
      star = key_one && held_char == CH_STAR;
      case (mode)
        S_FIRST: begin
          if (b == CH_DOLLAR || b == CH_AT) mode = S_TOKSTART;
          else follow_dot(b, last, 1'b0, r);
        end
        S_TOKSTART: begin
          if (b == CH_DOT) mode = S_AFTERDOT;
          else if (b == CH_LBRACK) mode = S_BROPEN;
          else err_seen = 1'b1;
        end
        S_AFTERDOT: follow_dot(b, last, 1'b0, r);
        S_AFTERREC: follow_dot(b, last, 1'b1, r);
        S_DOTKEY: begin
          if (b == CH_DOT || b == CH_LBRACK) begin
            r.token_end = 1'b1;
            r.token_kind = jpt_pkg::KIND_KEY;
            mode = (b == CH_DOT) ? S_AFTERDOT : S_BROPEN;
          end else if (b == CH_LPAREN || is_space(b)) begin
            err_seen = 1'b1;
          end else begin
            r.has_char = 1'b1;
            r.key_char = b;
            if (last) begin
              r.token_end = 1'b1;
              r.token_kind = jpt_pkg::KIND_KEY;
            end
          end
        end
        S_BROPEN: begin
          if (is_space(b)) begin
          end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            quote_single = (b == CH_SQUOTE);
            quoted_nonempty = 1'b0;
            mode = S_QUOTED;
          end else if (is_bare(b)) begin
            held_char = b;
            held_valid = 1'b1;
            key_one = 1'b1;
            mode = S_UKEY;
          end else begin
            err_seen = 1'b1;
          end
        end
        S_QUOTED: begin
          if (b == CH_BSLASH) begin
            mode = S_QESC;
          end else if (b == q) begin
            if (quoted_nonempty) mode = S_QCLOSE;
            else err_seen = 1'b1;
          end else begin
            r.has_char = 1'b1;
            r.key_char = b;
            quoted_nonempty = 1'b1;
          end
        end
        S_QESC: begin
          if (b == q || b == CH_BSLASH) begin
            r.has_char = 1'b1;
            r.key_char = b;
            quoted_nonempty = 1'b1;
            mode = S_QUOTED;
          end else begin
            err_seen = 1'b1;
          end
        end
        S_QCLOSE: begin
          if (is_space(b)) begin
          end else if (b == CH_RBRACK) begin
            r.token_end = 1'b1;
            r.token_kind = jpt_pkg::KIND_QUOTED;
            mode = S_TOKSTART;
          end else begin
            err_seen = 1'b1;
          end
        end
        S_UKEY: begin
          // Bare keys are one byte behind so that a lone star is never printed.
          if (is_bare(b)) begin
            r.has_char = 1'b1;
            r.key_char = held_char;
            held_char = b;
            held_valid = 1'b1;
            key_one = 1'b0;
          end else if (is_space(b) || b == CH_RBRACK) begin
            if (held_valid && !star) begin
              r.has_char = 1'b1;
              r.key_char = held_char;
            end
            held_valid = 1'b0;
            if (b == CH_RBRACK) begin
              r.token_end = 1'b1;
              r.token_kind = star ? jpt_pkg::KIND_WILDCARD : jpt_pkg::KIND_KEY;
              mode = S_TOKSTART;
            end else begin
              mode = S_UCLOSE;
            end
          end else begin
            err_seen = 1'b1;
          end
        end
        S_UCLOSE: begin
          if (is_space(b)) begin
          end else if (b == CH_RBRACK) begin
            r.token_end = 1'b1;
            r.token_kind = star ? jpt_pkg::KIND_WILDCARD : jpt_pkg::KIND_KEY;
            mode = S_TOKSTART;
          end else begin
            err_seen = 1'b1;
          end
        end
        default: err_seen = 1'b1;
      endcase
      if (last && !err_seen && mode != S_TOKSTART && mode != S_DOTKEY) err_seen = 1'b1;
    end
    if (err_seen) r = '0;
    r.path_error = err_seen;
    r.path_done = last;
    if (last) clear_scan();
    return r;
  endfunction

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    jpt_pkg::res_t got, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = scan_byte(path_byte_i, last_byte_i);
        pending_res.push_back(row_typed ? row_res : want);
      end
      if (out_valid_o && !out_stall_i) begin
        got.has_char = has_char_o;
        got.key_char = key_char_o;
        got.token_end = token_end_o;
        got.token_kind = jpt_pkg::kind_e'(token_kind_o);
        got.path_error = path_error_o;
        got.path_done = path_done_o;
        if (pending_res.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR @%0d: result %p arrived with nothing pending", cycle_cnt, got);
        end else begin
          want = pending_res.pop_front();
          if (got.has_char !== want.has_char || got.key_char !== want.key_char ||
              got.token_end !== want.token_end || got.token_kind !== want.token_kind ||
              got.path_error !== want.path_error || got.path_done !== want.path_done) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("ERROR @%0d: expected %p, got %p", cycle_cnt, want, got);
          end
          n_tokens += got.token_end;
          n_chars += got.has_char;
          if (got.path_done) begin
            n_paths++;
            n_bad_paths += got.path_error;
          end
        end
      end
    end
  end

  // Receiver stall: style redrawn when stall_phase[7:0] is zero; one style has no stalls.
  always @(negedge clk_i) begin
    stall_phase++;
    if (stall_phase[7:0] == 8'd0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      2: out_stall_i <= (stall_phase[2:0] < 3'd3);
      default: out_stall_i <= stall_phase[4];
    endcase
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] pb, input logic lb, input bit typed,
                           input jpt_pkg::res_t res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    path_byte_i <= pb;
    last_byte_i <= lb;
    row_typed <= typed;
    row_res <= res;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    burst_left--;
    n_items++;
  endtask

  function automatic void add_row(input logic [7:0] pb, input logic lb, input bit typed,
                                  input jpt_pkg::res_t res);
    path_row_t row;
    row.pb = pb;
    row.lb = lb;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [7:0] key_letter();
    case ($urandom_range(0, 3))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      2: return 8'("0" + $urandom_range(0, 9));
      default: return $urandom_range(0, 1) ? CH_USCORE : CH_DASH;
    endcase
  endfunction

  function automatic void add_ws();
    int unsigned n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) path_buf.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE :
                                  8'($urandom_range(9, 13)));
  endfunction

  function automatic void add_dot_key(input int unsigned n);
    repeat (n) path_buf.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) :
                                  key_letter());
  endfunction

  function automatic void add_quoted_bracket();
    logic [7:0]  q, c;
    int unsigned n, e;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
    path_buf.push_back(CH_LBRACK);
    add_ws();
    path_buf.push_back(q);
    repeat (n) begin
      e = $urandom_range(0, 19);
      if (e < 3) begin
        path_buf.push_back(CH_BSLASH);
        path_buf.push_back((e == 0) ? CH_BSLASH : (e == 1) ? q : 8'($urandom_range(0, 255)));
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == q || c == CH_BSLASH);
        path_buf.push_back(c);
      end
    end
    path_buf.push_back(q);
    add_ws();
    path_buf.push_back(CH_RBRACK);
  endfunction

  function automatic void add_bare_bracket();
    path_buf.push_back(CH_LBRACK);
    add_ws();
    if ($urandom_range(0, 4) == 0) begin
      path_buf.push_back(CH_STAR);
    end else begin
      repeat ($urandom_range(1, 5))
        path_buf.push_back(($urandom_range(0, 7) == 0) ? CH_STAR : key_letter());
    end
    add_ws();
    path_buf.push_back(CH_RBRACK);
  endfunction

  // Mostly well-formed paths with random keys; some are damaged or pure noise.
  function automatic void build_path();
    int unsigned pick, ntok;
    bit          bare_start;
    path_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) path_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    pick = $urandom_range(0, 9);
    bare_start = (pick >= 6);
    if (pick < 4) path_buf.push_back(CH_DOLLAR);
    else if (pick < 6) path_buf.push_back(CH_AT);
    ntok = $urandom_range(1, 5);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 4))
        0: begin
          path_buf.push_back(CH_DOT);
          add_dot_key($urandom_range(1, 6));
        end
        1: begin
          path_buf.push_back(CH_DOT);
          path_buf.push_back(CH_STAR);
        end
        2: begin
          path_buf.push_back(CH_DOT);
          path_buf.push_back(CH_DOT);
          case ($urandom_range(0, 2))
            0: add_dot_key($urandom_range(1, 4));
            1: path_buf.push_back(CH_STAR);
            default: add_quoted_bracket();
          endcase
        end
        3: add_quoted_bracket();
        default: add_bare_bracket();
      endcase
      // A path without a root marker reads its first byte as if a dot came before it.
      if (t == 0 && bare_start && path_buf[0] == CH_DOT && $urandom_range(0, 4) != 0)
        path_buf.delete(0);
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) path_buf[$urandom_range(0, path_buf.size() - 1)] = 8'($urandom_range(0, 255));
    else if (pick < 15) path_buf = path_buf[0:$urandom_range(0, path_buf.size() - 1)];
  endfunction

  // ---------------------------------------------------------------- run control

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned waited;
    clear_scan();

    add_row(CH_DOLLAR, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, jpt_pkg::KIND_QUOTED, 1'b0, 1'b1});
    // A lone dot is rejected as an error.
    add_row(CH_DOT,    1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, jpt_pkg::KIND_QUOTED, 1'b1, 1'b1});
    add_row(8'h00,     1'b1, 1'b1, '{1'b1, 8'h00, 1'b1, jpt_pkg::KIND_KEY,    1'b0, 1'b1});
    add_row(8'hFF,     1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, jpt_pkg::KIND_KEY,    1'b0, 1'b1});
    // @..*["\""][ * ]
    add_row(CH_AT,     1'b0, 1'b0, '0);
    add_row(CH_DOT,    1'b0, 1'b0, '0);
    add_row(CH_DOT,    1'b0, 1'b0, '0);
    add_row(CH_STAR,   1'b0, 1'b0, '0);
    add_row(CH_LBRACK, 1'b0, 1'b0, '0);
    add_row(CH_DQUOTE, 1'b0, 1'b0, '0);
    add_row(CH_BSLASH, 1'b0, 1'b0, '0);
    add_row(CH_DQUOTE, 1'b0, 1'b0, '0);
    add_row(CH_DQUOTE, 1'b0, 1'b0, '0);
    add_row(CH_RBRACK, 1'b0, 1'b0, '0);
    add_row(CH_LBRACK, 1'b0, 1'b0, '0);
    add_row(CH_SPACE,  1'b0, 1'b0, '0);
    add_row(CH_STAR,   1'b0, 1'b0, '0);
    add_row(CH_SPACE,  1'b0, 1'b0, '0);
    add_row(CH_RBRACK, 1'b1, 1'b0, '0);
    // Whitespace inside a dot key, then bytes swallowed by the sticky error.
    add_row("a",       1'b0, 1'b0, '0);
    add_row(CH_SPACE,  1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, jpt_pkg::KIND_QUOTED, 1'b1, 1'b0});
    add_row("q",       1'b0, 1'b0, '0);
    add_row(CH_LBRACK, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, jpt_pkg::KIND_QUOTED, 1'b1, 1'b1});
    // $[-7]
    add_row(CH_DOLLAR, 1'b0, 1'b0, '0);
    add_row(CH_LBRACK, 1'b0, 1'b0, '0);
    add_row(CH_DASH,   1'b0, 1'b0, '0);
    add_row("7",       1'b0, 1'b0, '0);
    add_row(CH_RBRACK, 1'b1, 1'b0, '0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].pb, directed_rows[i].lb, directed_rows[i].typed,
                directed_rows[i].res);

    while (n_items < directed_rows.size() + RAND_ITEMS) begin
      build_path();
      foreach (path_buf[i]) send_byte(path_buf[i], i == path_buf.size() - 1, 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_res.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (pending_res.size() != 0) begin
      $display("ERROR: %0d results never arrived", pending_res.size());
      mismatches += pending_res.size();
    end

    $display("Sent %0d path bytes in %0d paths (%0d of them rejected as malformed).",
             n_items, n_paths, n_bad_paths);
    $display("Saw %0d completed tokens and %0d key characters; %0d mismatches.",
             n_tokens, n_chars, mismatches);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ json_path_tokenizer_unit.f @@
sv/jpt_pkg.sv
sv/jpt_scan.sv
sv/json_path_tokenizer_unit.sv
tb/tb_json_path_tokenizer_unit.sv
